>>> sv/csq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csq_pkg: shared types and constants of the coalescing send queue
// Queue geometry, opcodes, word layouts and the controller/datapath
// command and status bundles.
// ----------------------------------------------------------------------------
package csq_pkg;

    localparam int DEPTH      = 16;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int CFG_W      = 5;
    localparam int LIM_W      = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int OPC_W      = 2;
    localparam int TYPE_W     = 8;
    localparam int PAY_W      = 16;
    localparam int QLEN_W     = 5;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [CFG_W-1:0] MAX_ENTRIES_RESET = CFG_W'(10);

    localparam logic [OPC_W-1:0] OP_PUSH  = 2'd0;
    localparam logic [OPC_W-1:0] OP_POP   = 2'd1;
    localparam logic [OPC_W-1:0] OP_CLEAR = 2'd2;

    localparam logic REG_MAX_ENTRIES = 1'b0;

    typedef struct packed {
        logic latch;    // capture the input word
        logic scan;     // compare one entry against the pushed type
        logic exec;     // carry out the operation
        logic publish;  // load the result word
    } csq_cmd_t;

    typedef struct packed {
        logic need_scan;  // input word asks for a replace on a non-empty queue
        logic hit;        // scanned entry matches the pushed type
        logic scan_last;  // scanned entry is the youngest one
        logic slot_free;  // output register can take a new word
    } csq_sts_t;

endpackage

>>> sv/csq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csq_ctrl: sequencer of the coalescing send queue
// Accepts one word at a time, runs the same-type scan where needed, the
// update and the result load in turn.
// ----------------------------------------------------------------------------
module csq_ctrl
    import csq_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    input  csq_sts_t sts,
    output csq_cmd_t cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_EXEC = 2'd2;
    localparam logic [1:0] ST_PUB  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        in_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                in_ready  = 1'b1;
                cmd.latch = in_valid;
                if (in_valid) begin
                    state_next = sts.need_scan ? ST_SCAN : ST_EXEC;
                end
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (sts.hit || sts.scan_last) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (sts.slot_free) begin
                    cmd.exec   = 1'b1;
                    state_next = ST_PUB;
                end
            end
            ST_PUB: begin
                cmd.publish = 1'b1;
                state_next  = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> sv/csq_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csq_datapath: entry storage and result register of the send queue
// Entries are kept oldest first in a shift array; removal at any position
// shifts the younger entries down by one.
// ----------------------------------------------------------------------------
module csq_datapath
    import csq_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [IN_DATA_W-1:0]  in_data,
    input  logic [CFG_W-1:0]      max_entries,
    input  csq_cmd_t              cmd,
    output csq_sts_t              sts,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [OUT_DATA_W-1:0] out_data
);

    logic [TYPE_W-1:0]     types_reg    [DEPTH];
    logic [TYPE_W-1:0]     types_next   [DEPTH];
    logic [PAY_W-1:0]      payloads_reg [DEPTH];
    logic [PAY_W-1:0]      payloads_next[DEPTH];
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic [IDX_W-1:0]      idx_reg;
    logic [OPC_W-1:0]      op_reg;
    logic [TYPE_W-1:0]     type_reg;
    logic [PAY_W-1:0]      payload_reg;
    logic                  idle_before_reg;
    logic                  ok_reg;
    logic                  start_reg;
    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    logic [OPC_W-1:0]  in_op;
    logic [TYPE_W-1:0] in_type;
    logic [PAY_W-1:0]  in_payload;
    logic              in_replace;
    logic [LIM_W-1:0]  limit;
    logic              push_full;
    logic              shift_en;
    logic [IDX_W-1:0]  shift_pos;
    logic              write_en;
    logic              head_valid;

    assign in_op      = in_data[OPC_W-1:0];
    assign in_type    = in_data[OPC_W +: TYPE_W];
    assign in_payload = in_data[OPC_W+TYPE_W +: PAY_W];
    assign in_replace = in_data[OPC_W+TYPE_W+PAY_W];

    // A limit above the storage depth behaves as the depth.
    assign limit = (LIM_W'(max_entries) > LIM_W'(DEPTH)) ? LIM_W'(DEPTH)
                                                           : LIM_W'(max_entries);
    assign push_full = (LIM_W'(count_reg) >= limit);

    assign sts.need_scan = (in_op == OP_PUSH) && in_replace && (count_reg != '0);
    assign sts.hit       = (types_reg[idx_reg] == type_reg);
    assign sts.scan_last = (CNT_W'(idx_reg) + CNT_W'(1) >= count_reg);
    assign sts.slot_free = !out_valid_reg || out_ready;

    always_comb begin
        shift_en   = 1'b0;
        shift_pos  = idx_reg;
        write_en   = 1'b0;
        count_next = count_reg;
        if (cmd.scan && sts.hit) begin
            shift_en   = 1'b1;
            count_next = count_reg - CNT_W'(1);
        end
        if (cmd.exec) begin
            case (op_reg)
                OP_PUSH: begin
                    if (!push_full) begin
                        write_en   = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                OP_POP: begin
                    if (count_reg != '0) begin
                        shift_en   = 1'b1;
                        shift_pos  = '0;
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                OP_CLEAR: begin
                    count_next = '0;
                end
                default: begin
                    count_next = count_reg;
                end
            endcase
        end
    end

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            types_next[i]    = types_reg[i];
            payloads_next[i] = payloads_reg[i];
            if (shift_en && (IDX_W'(i) >= shift_pos) && (i < DEPTH - 1)) begin
                types_next[i]    = types_reg[(i + 1) % DEPTH];
                payloads_next[i] = payloads_reg[(i + 1) % DEPTH];
            end
            if (write_en && (count_reg[IDX_W-1:0] == IDX_W'(i))) begin
                types_next[i]    = type_reg;
                payloads_next[i] = payload_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < DEPTH; i++) begin
            types_reg[i]    <= types_next[i];
            payloads_reg[i] <= payloads_next[i];
        end
        if (cmd.latch) begin
            op_reg          <= in_op;
            type_reg        <= in_type;
            payload_reg     <= in_payload;
            idle_before_reg <= !in_replace || (count_reg == '0);
        end
        if (cmd.latch) begin
            idx_reg <= '0;
        end else if (cmd.scan) begin
            idx_reg <= idx_reg + IDX_W'(1);
        end
        if (cmd.exec) begin
            ok_reg    <= !((op_reg == OP_PUSH) && push_full);
            start_reg <= (op_reg == OP_PUSH) && !push_full && (count_reg == '0)
                         && idle_before_reg;
        end
    end

    assign head_valid = (count_reg != '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (cmd.publish) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.publish) begin
            out_data_reg <= {head_valid ? payloads_reg[0] : PAY_W'(0),
                             head_valid ? types_reg[0] : TYPE_W'(0),
                             head_valid,
                             start_reg,
                             QLEN_W'(count_reg),
                             ok_reg};
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

>>> sv/coalescing_send_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coalescing_send_queue: bounded ordered send queue with replace by type
// Push, pop and clear words come in on the s_axis channel; each word yields
// exactly one result word on the m_axis channel.
// ----------------------------------------------------------------------------
// Usage:
//   Input word: opcode (push, pop head, clear), type tag, payload handle and
//   a replace flag that drops the oldest entry of the same type first.
//   Result word: success flag, queue length, start pulse and the head entry.
//   max_entries (APB address 0) sets the fill level at which pushes are
//   refused; write it only while the queue is idle.
//   After an input word is accepted, the same-type scan visits entries
//   (only for a push with replace on a non-empty queue, up to the queue
//   length, one entry per cycle), then the update and the result load follow.
//   The next input word is taken only once the result has been loaded.
//   Reset empties the queue and sets max_entries to 10.
//   The result sits in an output register; a stalled receiver does not
//   block the next input word, which waits in the update step until the
//   pending result has been taken.
// ----------------------------------------------------------------------------
module coalescing_send_queue
    import csq_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // opcode[1:0], item_type[9:2], payload[25:10], replace_same_type[26], zero fill
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // ok[0], queue_length[5:1], start_sending[6], head_valid[7],
    // head_type[15:8], head_payload[31:16]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    csq_cmd_t         cmd;
    csq_sts_t         sts;
    logic [CFG_W-1:0] max_entries_reg;
    logic             reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[APB_ADDR_W-1] == REG_MAX_ENTRIES);
    assign prdata  = reg_sel ? APB_DATA_W'(max_entries_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_entries_reg <= MAX_ENTRIES_RESET;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            max_entries_reg <= pwdata[CFG_W-1:0];
        end
    end

    csq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    csq_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_data     (s_axis_tdata),
        .max_entries (max_entries_reg),
        .cmd         (cmd),
        .sts         (sts),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_data    (m_axis_tdata)
    );

endmodule

>>> test/tb_coalescing_send_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_coalescing_send_queue: self-checking bench for the coalescing send queue
// A short table of directed words covers the empty queue, the refused push,
// replace by type and the limit extremes. It is followed by random phases
// under several fill limits, with gaps and stalls on both stream channels.
// Results are checked against the typed result of their table row or a queue model in the bench.
// ----------------------------------------------------------------------------
module tb_coalescing_send_queue;
    import csq_pkg::*;

    localparam logic [OPC_W-1:0] OP_NONE = 2'd3;
    localparam int SETTLE_CYCLES = 3 + DEPTH + 8;
    localparam int TIMEOUT_NS    = 2_000_000;
    localparam int N_PLAN        = 24;
    localparam int N_PHASES      = 12;
    localparam int PHASE_WORDS   = 140;
    localparam int IDLE_PCT      = 34;

    typedef enum logic {ROW_WORD, ROW_CFG} row_kind_e;

    // op[1:0], itype[9:2], payload[25:10], replace[26], zero fill
    typedef struct packed {
        logic [4:0]        fill;
        logic              replace;
        logic [PAY_W-1:0]  payload;
        logic [TYPE_W-1:0] itype;
        logic [OPC_W-1:0]  op;
    } word_t;

    // ok[0], qlen[5:1], start[6], head_valid[7], head_type[15:8], head_payload[31:16]
    typedef struct packed {
        logic [PAY_W-1:0]  head_payload;
        logic [TYPE_W-1:0] head_type;
        logic              head_valid;
        logic              start;
        logic [QLEN_W-1:0] qlen;
        logic              ok;
    } result_t;

    typedef struct packed {
        logic [TYPE_W-1:0] itype;
        logic [PAY_W-1:0]  payload;
    } entry_t;

    typedef struct {
        row_kind_e         kind;
        logic [OPC_W-1:0]  op;
        logic [TYPE_W-1:0] itype;
        logic [PAY_W-1:0]  payload;
        logic              replace;
        int                limit;
        logic              typed;
        logic              ok;
        int                qlen;
        logic              start;
        logic              head_valid;
        logic [TYPE_W-1:0] head_type;
        logic [PAY_W-1:0]  head_payload;
    } row_t;

    logic                  aclk;
    logic                  aresetn       = 1'b0;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic                  psel          = 1'b0;
    logic                  penable       = 1'b0;
    logic                  pwrite        = 1'b0;
    logic [APB_ADDR_W-1:0] paddr         = '0;
    logic [APB_DATA_W-1:0] pwdata        = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Queue model and its fill limit, plus the results still owed by the block.
    entry_t        queue_model[$];
    logic [4:0]    limit_model;
    result_t       owed_results[$];

    logic no_idle = 1'b0;
    int   errors = 0;
    int   words_sent = 0;
    int   results_seen = 0;
    int   limit_writes = 0;
    int   refused_pushes = 0;
    int   start_pulses = 0;
    int   replace_hits = 0;
    int   deepest = 0;

    // Columns: kind, op, type, payload, replace, limit, typed, then the typed
    // result: ok, length, start, head valid, head type, head payload.
    row_t plan [N_PLAN] = '{
        // empty queue right after reset
        '{ROW_WORD, OP_POP,   8'h00, 16'h0000, 1'b0, 0,  1'b1, 1'b1, 0, 1'b0, 1'b0, 8'h00, 16'h0000},
        '{ROW_WORD, OP_CLEAR, 8'h00, 16'h0000, 1'b0, 0,  1'b1, 1'b1, 0, 1'b0, 1'b0, 8'h00, 16'h0000},
        '{ROW_WORD, OP_NONE,  8'hFF, 16'hFFFF, 1'b1, 0,  1'b1, 1'b1, 0, 1'b0, 1'b0, 8'h00, 16'h0000},
        '{ROW_WORD, OP_PUSH,  8'h00, 16'h0000, 1'b0, 0,  1'b1, 1'b1, 1, 1'b1, 1'b1, 8'h00, 16'h0000},
        // replace with no matching type, then with matching types
        '{ROW_WORD, OP_PUSH,  8'hFF, 16'hFFFF, 1'b1, 0,  1'b1, 1'b1, 2, 1'b0, 1'b1, 8'h00, 16'h0000},
        '{ROW_WORD, OP_PUSH,  8'hFF, 16'h1234, 1'b1, 0,  1'b0, 1'b0, 0, 1'b0, 1'b0, 8'h00, 16'h0000},
        '{ROW_WORD, OP_PUSH,  8'h00, 16'hABCD, 1'b1, 0,  1'b0, 1'b0, 0, 1'b0, 1'b0, 8'h00, 16'h0000},
        '{ROW_WORD, OP_POP,   8'h00, 16'h0000, 1'b0, 0,  1'b0, 1'b0, 0, 1'b0, 1'b0, 8'h00, 16'h0000},
        '{ROW_WORD, OP_POP,   8'h00, 16'h0000, 1'b0, 0,  1'b0, 1'b0, 0, 1'b0, 1'b0, 8'h00, 16'h0000},
        // replacing the only entry gives no start pulse
        '{ROW_WORD, OP_PUSH,  8'h55, 16'hAAAA, 1'b1, 0,  1'b1, 1'b1, 1, 1'b1, 1'b1, 8'h55, 16'hAAAA},
        '{ROW_WORD, OP_PUSH,  8'h55, 16'h5555, 1'b1, 0,  1'b1, 1'b1, 1, 1'b0, 1'b1, 8'h55, 16'h5555},
        '{ROW_WORD, OP_NONE,  8'hAA, 16'h0F0F, 1'b0, 0,  1'b0, 1'b0, 0, 1'b0, 1'b0, 8'h00, 16'h0000},
        '{ROW_WORD, OP_CLEAR, 8'h00, 16'h0000, 1'b0, 0,  1'b1, 1'b1, 0, 1'b0, 1'b0, 8'h00, 16'h0000},
        '{ROW_CFG,  OP_NONE,  8'h00, 16'h0000, 1'b0, 1,  1'b0, 1'b0, 0, 1'b0, 1'b0, 8'h00, 16'h0000},
        '{ROW_WORD, OP_PUSH,  8'h11, 16'h0001, 1'b0, 0,  1'b1, 1'b1, 1, 1'b1, 1'b1, 8'h11, 16'h0001},
        '{ROW_WORD, OP_PUSH,  8'h22, 16'h0002, 1'b0, 0,  1'b1, 1'b0, 1, 1'b0, 1'b1, 8'h11, 16'h0001},
        '{ROW_WORD, OP_PUSH,  8'h11, 16'h0003, 1'b1, 0,  1'b1, 1'b1, 1, 1'b0, 1'b1, 8'h11, 16'h0003},
        // a zero limit refuses the push even after the replace removed an entry
        '{ROW_CFG,  OP_NONE,  8'h00, 16'h0000, 1'b0, 0,  1'b0, 1'b0, 0, 1'b0, 1'b0, 8'h00, 16'h0000},
        '{ROW_WORD, OP_PUSH,  8'h11, 16'h0004, 1'b1, 0,  1'b1, 1'b0, 0, 1'b0, 1'b0, 8'h00, 16'h0000},
        '{ROW_WORD, OP_PUSH,  8'h33, 16'h8001, 1'b0, 0,  1'b1, 1'b0, 0, 1'b0, 1'b0, 8'h00, 16'h0000},
        '{ROW_CFG,  OP_NONE,  8'h00, 16'h0000, 1'b0, 31, 1'b0, 1'b0, 0, 1'b0, 1'b0, 8'h00, 16'h0000},
        '{ROW_WORD, OP_PUSH,  8'h44, 16'hFFFF, 1'b0, 0,  1'b1, 1'b1, 1, 1'b1, 1'b1, 8'h44, 16'hFFFF},
        '{ROW_WORD, OP_PUSH,  8'h7E, 16'h8000, 1'b1, 0,  1'b0, 1'b0, 0, 1'b0, 1'b0, 8'h00, 16'h0000},
        '{ROW_WORD, OP_POP,   8'h00, 16'h0000, 1'b0, 0,  1'b0, 1'b0, 0, 1'b0, 1'b0, 8'h00, 16'h0000}
    };

    int phase_limit [8] = '{16, 31, 1, 0, 2, 10, 16, 8};

    coalescing_send_queue u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("timeout with %0d results still owed", owed_results.size());
        $display("status: fail");
        $finish;
    end

    // Applies one word to the queue model and returns the result it must give.
    function automatic result_t queue_apply(input word_t w);
        result_t r;
        entry_t  e;
        int      eff_limit;
        int      fill_before;
        int      i;
        logic    hit;
        r = '0;
        r.ok = 1'b1;
        fill_before = 0;
        case (w.op)
            OP_PUSH: begin
                eff_limit = (int'(limit_model) < DEPTH) ? int'(limit_model) : DEPTH;
                if (w.replace) begin
                    fill_before = queue_model.size();
                    hit = 1'b0;
                    for (i = 0; i < queue_model.size() && !hit; i++) begin
                        if (queue_model[i].itype == w.itype) begin
                            queue_model.delete(i);
                            hit = 1'b1;
                            replace_hits++;
                        end
                    end
                end
                // The capacity check comes after the replace step.
                if (queue_model.size() >= eff_limit) begin
                    r.ok = 1'b0;
                    refused_pushes++;
                end else begin
                    e.itype = w.itype;
                    e.payload = w.payload;
                    queue_model.push_back(e);
                    if (queue_model.size() == 1 && fill_before == 0) begin
                        r.start = 1'b1;
                        start_pulses++;
                    end
                end
            end
            OP_POP: begin
                if (queue_model.size() != 0) void'(queue_model.pop_front());
            end
            OP_CLEAR: begin
                queue_model.delete();
            end
            default: begin
            end
        endcase
        r.qlen = QLEN_W'(queue_model.size());
        if (queue_model.size() != 0) begin
            r.head_valid = 1'b1;
            r.head_type = queue_model[0].itype;
            r.head_payload = queue_model[0].payload;
        end
        if (queue_model.size() > deepest) deepest = queue_model.size();
        return r;
    endfunction

    task automatic send_word(input word_t w, input logic typed, input result_t typed_res);
        result_t predicted;
        if (!no_idle) begin
            while ($urandom_range(0, 99) < IDLE_PCT) begin
                s_axis_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        predicted = queue_apply(w);
        owed_results.push_back(typed ? typed_res : predicted);
        words_sent++;
    endtask

    // The limit is only rewritten once the queue has answered every word.
    task automatic write_limit(input int value);
        s_axis_tvalid <= 1'b0;
        while (owed_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(4 * int'(REG_MAX_ENTRIES));
        pwdata  <= APB_DATA_W'(value);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        limit_model = value[4:0];
        limit_writes++;
    endtask

    always @(posedge aclk) begin
        m_axis_tready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    always @(posedge aclk) begin : check_results
        result_t got;
        result_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            results_seen++;
            if (owed_results.size() == 0) begin
                errors++;
                if (errors <= 10) $display("result word %0d arrived with none owed: %h",
                                           results_seen, got);
            end else begin
                want = owed_results.pop_front();
                if (got.ok !== want.ok || got.qlen !== want.qlen || got.start !== want.start
                    || got.head_valid !== want.head_valid || got.head_type !== want.head_type
                    || got.head_payload !== want.head_payload) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("result word %0d differs:", results_seen);
                        $display("  expected ok=%0d len=%0d start=%0d head=%0d type=%h pay=%h",
                                 want.ok, want.qlen, want.start, want.head_valid,
                                 want.head_type, want.head_payload);
                        $display("  actual   ok=%0d len=%0d start=%0d head=%0d type=%h pay=%h",
                                 got.ok, got.qlen, got.start, got.head_valid,
                                 got.head_type, got.head_payload);
                    end
                end
            end
        end
    end

    initial begin : stimulus
        word_t       w;
        result_t     typed_res;
        logic [7:0]  type_base;
        int          push_pct;
        int          clear_pct;
        int          roll;
        limit_model = MAX_ENTRIES_RESET;
        queue_model.delete();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int r = 0; r < N_PLAN; r++) begin
            if (plan[r].kind == ROW_CFG) begin
                write_limit(plan[r].limit);
            end else begin
                w = '0;
                w.op = plan[r].op;
                w.itype = plan[r].itype;
                w.payload = plan[r].payload;
                w.replace = plan[r].replace;
                typed_res = '0;
                typed_res.ok = plan[r].ok;
                typed_res.qlen = QLEN_W'(plan[r].qlen);
                typed_res.start = plan[r].start;
                typed_res.head_valid = plan[r].head_valid;
                typed_res.head_type = plan[r].head_type;
                typed_res.head_payload = plan[r].head_payload;
                send_word(w, plan[r].typed, typed_res);
            end
        end

        // Random phases: alternate push-heavy phases that fill the queue with
        // balanced ones; types mostly come from a small set so replaces hit.
        for (int ph = 0; ph < N_PHASES; ph++) begin
            write_limit(ph < 8 ? phase_limit[ph] : int'($urandom_range(0, 31)));
            no_idle = (ph == 3);
            push_pct = (ph % 2 == 0) ? 75 : 45;
            clear_pct = (ph % 2 == 0) ? 1 : 5;
            type_base = 8'($urandom);
            for (int n = 0; n < PHASE_WORDS; n++) begin
                roll = $urandom_range(0, 99);
                w = '0;
                if (roll < push_pct) w.op = OP_PUSH;
                else if (roll < push_pct + clear_pct) w.op = OP_CLEAR;
                else if (roll < push_pct + clear_pct + 3) w.op = OP_NONE;
                else w.op = OP_POP;
                w.itype = ($urandom_range(0, 99) < 70) ? type_base + 8'($urandom_range(0, 3))
                                                       : 8'($urandom_range(0, 255));
                w.payload = 16'($urandom);
                w.replace = 1'($urandom_range(0, 1));
                send_word(w, 1'b0, '0);
            end
        end
        no_idle = 1'b0;

        s_axis_tvalid <= 1'b0;
        while (owed_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("sent %0d words, checked %0d results, %0d limit writes, %0d errors",
                 words_sent, results_seen, limit_writes, errors);
        $display("saw %0d refused pushes, %0d start pulses, %0d replace hits, deepest %0d",
                 refused_pushes, start_pulses, replace_hits, deepest);
        if (errors == 0 && owed_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
